// ----- src/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)
`endif

`endif

// ----- src/spca_pkg.sv -----
package spca_pkg;

  localparam int SLOT_CAP = 8;
  localparam int IDX_W    = 3;
  localparam int CNT_W    = 4;
  localparam int CUST_W   = 16;
  localparam int TT_W     = 16;
  localparam int DEP_W    = 18;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_ASSIGN,
    OP_TICK,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic adv;
  } ctl_t;

  typedef struct packed {
    logic [CUST_W-1:0] cust;
    logic [TT_W-1:0]   tt;
    logic [DEP_W-1:0]  dep;
  } item_t;

  typedef struct packed {
    logic tok;
    logic found;
  } link_t;

  typedef struct packed {
    logic load;
    logic depart;
    logic busy_after;
    logic hit;
  } stat_t;

  typedef struct packed {
    logic [CUST_W-1:0] cust;
    logic [DEP_W-1:0]  dep;
  } slot_t;

endpackage

// ----- src/spca_if.sv -----
interface spca_req_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [15:0] customer_number;
  logic [15:0] arrival_time;
  logic [15:0] waiting_time;
  logic [15:0] transaction_time;

  modport source (
    output valid, action, customer_number, arrival_time, waiting_time, transaction_time,
    input  ready
  );
  modport sink (
    input  valid, action, customer_number, arrival_time, waiting_time, transaction_time,
    output ready
  );
endinterface

interface spca_rsp_if;
  logic        valid;
  logic        ready;
  logic        assign_ok;
  logic [2:0]  server_index;
  logic        departed;
  logic [15:0] departed_customer;
  logic [17:0] departure_time;
  logic [3:0]  busy_count;
  logic        last_of_run;

  modport source (
    output valid, assign_ok, server_index, departed, departed_customer, departure_time,
           busy_count, last_of_run,
    input  ready
  );
  modport sink (
    input  valid, assign_ok, server_index, departed, departed_customer, departure_time,
           busy_count, last_of_run,
    output ready
  );
endinterface

// ----- src/server_pool_countdown_allocator_top.sv -----
// Server pool allocator with per-slot countdown timers.
// request channel (valid/ready): action 1 assigns the customer to the lowest
// free slot below servers_in_use, action 0 is one tick for all busy slots.
// result channel (valid/ready): one result per assign, one per departing slot
// on a tick (ascending slot order, last_of_run on the final one), or a single
// empty result when a tick frees nothing. busy_count is the count after update.
// cfg_wr_en/cfg_wr_data write servers_in_use (reset 8); write only while idle.
// Operation: a token walks the active slot chain one slot per cycle, except
// that a stalled receiver holds the departure walk. An assign, or a tick with
// no departure, is one walk of the chain; a tick with departures is a
// countdown walk followed by a departure walk. A new request is taken once
// the previous item is done; its last result may still wait in the output
// register. With no active slot the request skips the walk.
// When the receiver stalls, the departure walk holds on the pending slot.
// Reset (synchronous, active high) frees every slot and empties the output.
`include "assert_macros.svh"

module server_pool_countdown_allocator_top #(
  parameter int NUM_SERVERS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,
  spca_req_if.sink    request,
  spca_rsp_if.source  result
);

  localparam int IW  = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
  localparam int CAP = (NUM_SERVERS < spca_pkg::SLOT_CAP) ? NUM_SERVERS
                                                          : spca_pkg::SLOT_CAP;

  logic [spca_pkg::CNT_W-1:0] servers_in_use;
  logic [spca_pkg::CNT_W-1:0] n_eff;

  spca_pkg::ctl_t   ctl;
  spca_pkg::item_t  item;
  logic             inject;
  spca_pkg::link_t  head;
  spca_pkg::link_t  links [NUM_SERVERS];
  spca_pkg::stat_t  stats [NUM_SERVERS];
  spca_pkg::slot_t  slots [NUM_SERVERS];
  spca_pkg::stat_t  stat_any;
  spca_pkg::slot_t  data_any;
  logic [NUM_SERVERS-1:0] tok_vec;

  always_ff @(posedge clk) begin
    if (rst) begin
      servers_in_use <= spca_pkg::CNT_W'(8);
    end else if (cfg_wr_en) begin
      servers_in_use <= cfg_wr_data;
    end
  end

  assign n_eff = (servers_in_use > spca_pkg::CNT_W'(CAP)) ? spca_pkg::CNT_W'(CAP)
                                                          : servers_in_use;

  assign head.tok   = inject;
  assign head.found = 1'b0;

  for (genvar k = 0; k < NUM_SERVERS; k++) begin : g_cell
    localparam logic [IW:0] KV = (IW + 1)'(k);
    logic active;
    assign active     = (KV < (IW + 1)'(n_eff));
    assign tok_vec[k] = links[k].tok;

    spca_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .active (active),
      .ctl    (ctl),
      .item   (item),
      .left   ((k == 0) ? head : links[(k == 0) ? 0 : k - 1]),
      .right  (links[k]),
      .stat   (stats[k]),
      .data   (slots[k])
    );
  end

  always_comb begin
    stat_any = '0;
    data_any = '0;
    for (int k = 0; k < NUM_SERVERS; k++) begin
      stat_any = stat_any | stats[k];
      data_any = data_any | slots[k];
    end
  end

  spca_seq #(
    .NUM_SERVERS (NUM_SERVERS)
  ) u_seq (
    .clk     (clk),
    .rst     (rst),
    .n_eff   (n_eff),
    .request (request),
    .result  (result),
    .ctl     (ctl),
    .item    (item),
    .inject  (inject),
    .stat    (stat_any),
    .data    (data_any)
  );

  `ASSERT_PROP(a_one_token, clk, rst, $onehot0(tok_vec))
  `ASSERT_NEVER(a_idle_no_token, clk, rst, request.ready && (|tok_vec))
  `ASSERT_NEVER(a_token_in_range, clk, rst,
    (|tok_vec) && !(|(tok_vec & ((NUM_SERVERS)'(1) << n_eff) - (NUM_SERVERS)'(1))))

endmodule

// ----- src/spca_cell.sv -----
module spca_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             active,
  input  spca_pkg::ctl_t   ctl,
  input  spca_pkg::item_t  item,
  input  spca_pkg::link_t  left,
  output spca_pkg::link_t  right,
  output spca_pkg::stat_t  stat,
  output spca_pkg::slot_t  data
);

  logic                          tok;
  logic                          found;
  logic                          busy;
  logic                          pend;
  logic [spca_pkg::TT_W-1:0]     rem;
  logic [spca_pkg::CUST_W-1:0]   cust;
  logic [spca_pkg::DEP_W-1:0]    dep;

  logic act;
  logic is_assign;
  logic is_tick;
  logic last_tick;

  assign act       = tok & ctl.adv;
  assign is_assign = (ctl.op == spca_pkg::OP_ASSIGN);
  assign is_tick   = (ctl.op == spca_pkg::OP_TICK);
  assign last_tick = (rem == spca_pkg::TT_W'(1));

  assign stat.load       = act & is_assign & ~busy & ~found;
  assign stat.depart     = act & is_tick & busy & last_tick;
  assign stat.busy_after = act & ((is_assign & (busy | ~found))
                                | (is_tick & busy & ~last_tick));
  assign stat.hit        = tok & pend & (ctl.op == spca_pkg::OP_EMIT);

  assign right.tok   = tok;
  assign right.found = found | (tok & is_assign & ~busy);

  assign data.cust = tok ? cust : '0;
  assign data.dep  = tok ? dep  : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok   <= 1'b0;
      found <= 1'b0;
      busy  <= 1'b0;
      pend  <= 1'b0;
      rem   <= '0;
    end else begin
      if (ctl.adv) begin
        tok   <= left.tok & active;
        found <= left.found;
      end
      if (act) begin
        case (ctl.op)
          spca_pkg::OP_ASSIGN: begin
            if (!busy && !found) begin
              busy <= 1'b1;
              rem  <= item.tt;
            end
          end
          spca_pkg::OP_TICK: begin
            if (busy) begin
              rem <= rem - spca_pkg::TT_W'(1);
              if (last_tick) begin
                busy <= 1'b0;
                pend <= 1'b1;
              end
            end
          end
          spca_pkg::OP_EMIT: begin
            pend <= 1'b0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stat.load) begin
      cust <= item.cust;
      dep  <= item.dep;
    end
  end

endmodule

// ----- src/spca_seq.sv -----
`include "assert_macros.svh"

module spca_seq #(
  parameter int NUM_SERVERS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [spca_pkg::CNT_W-1:0]    n_eff,
  spca_req_if.sink                      request,
  spca_rsp_if.source                    result,
  output spca_pkg::ctl_t                ctl,
  output spca_pkg::item_t               item,
  output logic                          inject,
  input  spca_pkg::stat_t               stat,
  input  spca_pkg::slot_t               data
);

  localparam int IW = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT,
    S_RESULT
  } state_t;

  state_t                              state;
  logic [IW-1:0]                       idx;
  logic                                action;
  logic [spca_pkg::CNT_W-1:0]          count;
  logic                                found;
  logic [spca_pkg::IDX_W-1:0]          found_idx;
  logic                                any_dep;
  logic [IW-1:0]                       last_dep;

  logic                                out_valid;
  logic                                out_ok;
  logic [spca_pkg::IDX_W-1:0]          out_idx;
  logic                                out_dep;
  logic [spca_pkg::CUST_W-1:0]         out_cust;
  logic [spca_pkg::DEP_W-1:0]          out_time;
  logic [spca_pkg::CNT_W-1:0]          out_busy;
  logic                                out_last;

  logic                                out_free;
  logic                                out_load;
  logic                                last_idx;
  logic                                will_emit;
  logic [spca_pkg::TT_W-1:0]           tt_eff;

  assign out_free  = ~out_valid | result.ready;
  assign out_load  = ((state == S_EMIT) & stat.hit & out_free)
                   | ((state == S_RESULT) & out_free);
  assign last_idx  = ((spca_pkg::CNT_W'(idx) + spca_pkg::CNT_W'(1)) == n_eff);
  assign will_emit = ~action & (any_dep | stat.depart);
  assign tt_eff    = (request.transaction_time == '0) ? spca_pkg::TT_W'(1)
                                                       : request.transaction_time;

  assign request.ready = (state == S_IDLE);

  always_comb begin
    ctl.op  = spca_pkg::OP_NONE;
    ctl.adv = 1'b1;
    inject  = 1'b0;
    case (state)
      S_IDLE: begin
        inject = request.valid & (n_eff != '0);
      end
      S_SCAN: begin
        ctl.op = action ? spca_pkg::OP_ASSIGN : spca_pkg::OP_TICK;
        inject = last_idx & will_emit;
      end
      S_EMIT: begin
        ctl.op  = spca_pkg::OP_EMIT;
        ctl.adv = ~stat.hit | out_free;
      end
      S_RESULT: begin
        ctl.adv = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (request.valid) begin
            action    <= request.action;
            item.cust <= request.customer_number;
            item.tt   <= tt_eff;
            item.dep  <= spca_pkg::DEP_W'(request.arrival_time)
                       + spca_pkg::DEP_W'(request.waiting_time)
                       + spca_pkg::DEP_W'(tt_eff);
            count     <= '0;
            found     <= 1'b0;
            found_idx <= '0;
            any_dep   <= 1'b0;
            idx       <= '0;
            state     <= (n_eff == '0) ? S_RESULT : S_SCAN;
          end
        end
        S_SCAN: begin
          count <= count + spca_pkg::CNT_W'(stat.busy_after);
          if (stat.load) begin
            found     <= 1'b1;
            found_idx <= spca_pkg::IDX_W'(idx);
          end
          if (stat.depart) begin
            any_dep  <= 1'b1;
            last_dep <= idx;
          end
          if (last_idx) begin
            idx   <= '0;
            state <= will_emit ? S_EMIT : S_RESULT;
          end else begin
            idx <= idx + IW'(1);
          end
        end
        S_EMIT: begin
          if (stat.hit && out_free) begin
            out_ok    <= 1'b0;
            out_idx   <= spca_pkg::IDX_W'(idx);
            out_dep   <= 1'b1;
            out_cust  <= data.cust;
            out_time  <= data.dep;
            out_busy  <= count;
            out_last  <= (idx == last_dep);
          end
          if (ctl.adv) begin
            if (last_idx) begin
              state <= S_IDLE;
            end else begin
              idx <= idx + IW'(1);
            end
          end
        end
        S_RESULT: begin
          if (out_free) begin
            out_ok    <= found;
            out_idx   <= found ? found_idx : '0;
            out_dep   <= 1'b0;
            out_cust  <= '0;
            out_time  <= '0;
            out_busy  <= count;
            out_last  <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign result.valid             = out_valid;
  assign result.assign_ok         = out_ok;
  assign result.server_index      = out_idx;
  assign result.departed          = out_dep;
  assign result.departed_customer = out_cust;
  assign result.departure_time    = out_time;
  assign result.busy_count        = out_busy;
  assign result.last_of_run       = out_last;

  // a stalled departure keeps its token in place
  `ASSERT_PROP(a_emit_hold, clk, rst,
    (state == S_EMIT && stat.hit && !out_free) |=> (state == S_EMIT && stat.hit))
  `ASSERT_NEVER(a_busy_range, clk, rst, out_valid && (out_busy > n_eff))
  `ASSERT_NEVER(a_slot_range, clk, rst,
    out_valid && (out_ok || out_dep) && (spca_pkg::CNT_W'(out_idx) >= n_eff))

endmodule

// ----- bench/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CUST_W = spca_pkg::CUST_W;
  localparam int TT_W   = spca_pkg::TT_W;
  localparam int IDX_W  = spca_pkg::IDX_W;
  localparam int DEP_W  = spca_pkg::DEP_W;
  localparam int CNT_W  = spca_pkg::CNT_W;

  localparam int POOL = 8;
  localparam int SETTLE = 2 * POOL + 4;
  localparam int RANDOM_ITEMS = 410;
  localparam logic [3:0] POOL_PLAN [8] = '{4'd1, 4'd8, 4'd3, 4'd9, 4'd5, 4'd2, 4'd8, 4'd6};

  typedef enum logic {
    ACT_TICK   = 1'b0,
    ACT_ASSIGN = 1'b1
  } action_t;

  typedef struct packed {
    action_t           action;
    logic [CUST_W-1:0] cust;
    logic [15:0]       arrival;
    logic [15:0]       queued;
    logic [TT_W-1:0]   service;
  } customer_req_t;

  typedef struct packed {
    logic              ok;
    logic [IDX_W-1:0]  idx;
    logic              dep;
    logic [CUST_W-1:0] cust;
    logic [DEP_W-1:0]  dtime;
    logic [CNT_W-1:0]  busy;
    logic              last;
  } service_result_t;

  logic       clk;
  logic       rst;
  logic       cfg_wr_en;
  logic [3:0] cfg_wr_data;

  spca_req_if req_ch();
  spca_rsp_if res_ch();

  server_pool_countdown_allocator_top #(.NUM_SERVERS(POOL)) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .request    (req_ch),
    .result     (res_ch)
  );

  // pool shadow
  logic [3:0]        pool_size;
  logic              slot_busy [POOL];
  logic [TT_W-1:0]   slot_left [POOL];
  logic [CUST_W-1:0] slot_cust [POOL];
  logic [DEP_W-1:0]  slot_done [POOL];

  customer_req_t   pending_requests [$];
  service_result_t expected_results [$];
  customer_req_t   in_flight;

  bit no_idle;
  int idle_left;
  int stall_left;
  int queued_total;
  int requests_taken;
  int results_seen;
  int departures_seen;
  int refusals_seen;
  int pool_settings;
  int mismatches;

  always #5 clk = ~clk;

  function automatic int busy_in_use(input int n);
    int c;
    c = 0;
    for (int i = 0; i < n; i++)
      if (slot_busy[i]) c++;
    return c;
  endfunction

  function automatic void serve_request(input customer_req_t rq);
    int n;
    int busy;
    int freed [$];
    logic [TT_W-1:0] svc;
    service_result_t r;
    n = (pool_size > POOL) ? POOL : int'(pool_size);
    r = '0;
    r.last = 1'b1;
    if (rq.action == ACT_ASSIGN) begin
      svc = (rq.service == '0) ? TT_W'(1) : rq.service;
      for (int i = 0; i < n; i++) begin
        if (!slot_busy[i]) begin
          slot_busy[i] = 1'b1;
          slot_left[i] = svc;
          slot_cust[i] = rq.cust;
          slot_done[i] = DEP_W'(rq.arrival) + DEP_W'(rq.queued) + DEP_W'(svc);
          r.ok = 1'b1;
          r.idx = IDX_W'(i);
          break;
        end
      end
      if (!r.ok) refusals_seen++;
      r.busy = CNT_W'(busy_in_use(n));
      expected_results.push_back(r);
      return;
    end
    for (int i = 0; i < n; i++) begin
      if (slot_busy[i]) begin
        slot_left[i] = slot_left[i] - 1'b1;
        if (slot_left[i] == '0) begin
          slot_busy[i] = 1'b0;
          freed.push_back(i);
        end
      end
    end
    busy = busy_in_use(n);
    r.busy = CNT_W'(busy);
    if (freed.size() == 0) begin
      expected_results.push_back(r);
      return;
    end
    foreach (freed[k]) begin
      r.idx = IDX_W'(freed[k]);
      r.dep = 1'b1;
      r.cust = slot_cust[freed[k]];
      r.dtime = slot_done[freed[k]];
      r.last = (k == freed.size() - 1);
      expected_results.push_back(r);
    end
  endfunction

  task automatic report_mismatch(input string what, input service_result_t want,
                                 input service_result_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: want ok=%0d idx=%0d dep=%0d cust=%h time=%h busy=%0d last=%0d",
               $realtime, what, want.ok, want.idx, want.dep, want.cust, want.dtime,
               want.busy, want.last);
    if (mismatches <= 10)
      $display("    got ok=%0d idx=%0d dep=%0d cust=%h time=%h busy=%0d last=%0d",
               got.ok, got.idx, got.dep, got.cust, got.dtime, got.busy, got.last);
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      idle_left = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        serve_request(in_flight);
        requests_taken++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (idle_left > 0) begin
          idle_left--;
          req_ch.valid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          in_flight = pending_requests.pop_front();
          req_ch.action <= in_flight.action;
          req_ch.customer_number <= in_flight.cust;
          req_ch.arrival_time <= in_flight.arrival;
          req_ch.waiting_time <= in_flight.queued;
          req_ch.transaction_time <= in_flight.service;
          req_ch.valid <= 1'b1;
          idle_left = no_idle ? 0 : $urandom_range(0, 9);
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    service_result_t got;
    service_result_t want;
    if (rst) begin
      res_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        got = {res_ch.assign_ok, res_ch.server_index, res_ch.departed,
               res_ch.departed_customer, res_ch.departure_time, res_ch.busy_count,
               res_ch.last_of_run};
        results_seen++;
        if (got.dep) departures_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", '0, got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) report_mismatch("result mismatch", want, got);
        end
        stall_left = no_idle ? 0 : $urandom_range(0, 9);
      end
      if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  task automatic queue_one(input action_t act, input logic [15:0] cust,
                           input logic [15:0] arrival, input logic [15:0] queued,
                           input logic [15:0] service);
    customer_req_t rq;
    rq.action = act;
    rq.cust = cust;
    rq.arrival = arrival;
    rq.queued = queued;
    rq.service = service;
    pending_requests.push_back(rq);
    queued_total++;
  endtask

  task automatic queue_mix(input int count);
    int assign_pct;
    int pick;
    logic [15:0] svc;
    assign_pct = $urandom_range(35, 65);
    repeat (count) begin
      pick = $urandom_range(1, 100);
      if (pick <= 70) svc = 16'($urandom_range(0, 6));
      else if (pick <= 95) svc = 16'($urandom_range(7, 40));
      else if (pick <= 99) svc = 16'($urandom_range(41, 300));
      else svc = 16'($urandom);
      queue_one(($urandom_range(1, 100) <= assign_pct) ? ACT_ASSIGN : ACT_TICK,
                16'($urandom),
                $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 200)),
                $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 50)),
                svc);
    end
  endtask

  task automatic wait_pool_quiet();
    while (requests_taken < queued_total || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_pool(input logic [3:0] count);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= count;
    pool_size = count;
    pool_settings++;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    #4_000_000;
    $display("server_pool_countdown_allocator_top test failed");
    $finish;
  end

  initial begin
    int random_total;
    int phase;
    int len;
    clk = 1'b0;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    req_ch.valid = 1'b0;
    req_ch.action = 1'b0;
    req_ch.customer_number = '0;
    req_ch.arrival_time = '0;
    req_ch.waiting_time = '0;
    req_ch.transaction_time = '0;
    res_ch.ready = 1'b0;
    pool_size = 4'd8;
    for (int i = 0; i < POOL; i++) begin
      slot_busy[i] = 1'b0;
      slot_left[i] = '0;
      slot_cust[i] = '0;
      slot_done[i] = '0;
    end
    no_idle = 1'b0;
    random_total = 0;
    phase = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty tick, zero service time at field maxima, then its departure
    queue_one(ACT_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    queue_one(ACT_ASSIGN, 16'hffff, 16'hffff, 16'hffff, 16'h0000);
    queue_one(ACT_TICK, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    // fill the pool; the last slot holds for the rest of the run
    queue_one(ACT_ASSIGN, 16'h0000, 16'h0000, 16'h0000, 16'd1);
    queue_one(ACT_ASSIGN, 16'h0001, 16'hffff, 16'h0000, 16'd1);
    queue_one(ACT_ASSIGN, 16'h8000, 16'h0000, 16'hffff, 16'd2);
    queue_one(ACT_ASSIGN, 16'h7fff, 16'h1234, 16'h4321, 16'd2);
    queue_one(ACT_ASSIGN, 16'haaaa, 16'h5555, 16'haaaa, 16'd3);
    queue_one(ACT_ASSIGN, 16'h5555, 16'haaaa, 16'h5555, 16'd5);
    queue_one(ACT_ASSIGN, 16'hffff, 16'h00ff, 16'hff00, 16'h0000);
    queue_one(ACT_ASSIGN, 16'h0f0f, 16'h0000, 16'h0000, 16'hffff);
    // pool full
    queue_one(ACT_ASSIGN, 16'h1111, 16'h0001, 16'h0001, 16'd4);
    repeat (5) queue_one(ACT_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    wait_pool_quiet();

    // no slot in use
    set_pool(4'd0);
    queue_one(ACT_ASSIGN, 16'h2222, 16'h0010, 16'h0020, 16'd3);
    queue_one(ACT_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    wait_pool_quiet();

    // count above the pool size
    set_pool(4'd15);
    queue_mix(6);
    wait_pool_quiet();

    while (random_total < RANDOM_ITEMS) begin
      set_pool(phase < 8 ? POOL_PLAN[phase] : 4'($urandom_range(1, 15)));
      no_idle = ($urandom_range(0, 3) == 0);
      len = $urandom_range(30, 70);
      queue_mix(len);
      random_total += len;
      phase++;
      wait_pool_quiet();
    end

    if (expected_results.size() != 0)
      report_mismatch("missing result", expected_results[0], '0);
    $display("%0d requests over %0d pool size settings, %0d results, %0d departures",
             requests_taken, pool_settings + 1, results_seen, departures_seen);
    $display("%0d assign requests found the pool full", refusals_seen);
    if (mismatches == 0)
      $display("server_pool_countdown_allocator_top test passed");
    else
      $display("server_pool_countdown_allocator_top test failed");
    $finish;
  end

endmodule
